FILE: sv/gslm_pkg.sv
// Shared constants, types and the neighbour comparison for the strict local-minimum detector.
`default_nettype none

package gslm_pkg;

    localparam int MAX_COLS      = 1024;
    localparam int MAX_ROWS      = 1024;
    localparam int PIXEL_BITS    = 16;
    localparam int ROW_BITS      = 10;
    localparam int COL_BITS      = 10;
    localparam int CNT_BITS      = 11;
    localparam int CFG_IDX_BITS  = 2;

    localparam int WIN_DIM       = 3;
    localparam int WIN_SIZE      = WIN_DIM * WIN_DIM;
    localparam int WIN_IDX_BITS  = $clog2(WIN_SIZE);
    localparam int NEIGHBOURS    = 8;

    localparam int DEC_COUNT     = 4;
    localparam int DEC_ABOVE_LEFT = 0;
    localparam int DEC_ABOVE     = 1;
    localparam int DEC_LEFT      = 2;
    localparam int DEC_HERE      = 3;

    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_BITS-1:0] MAX_ROWS_CNT = CNT_BITS'(MAX_ROWS);
    localparam logic [CNT_BITS-1:0] MAX_COLS_CNT = CNT_BITS'(MAX_COLS);

    localparam int OFF_ROW [NEIGHBOURS] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    localparam int OFF_COL [NEIGHBOURS] = '{-1, 0, 1, -1, 1, -1, 0, 1};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROW_COUNT = CFG_IDX_BITS'(0),
        CFG_COL_COUNT = CFG_IDX_BITS'(1)
    } cfg_reg_t;

    typedef logic signed [PIXEL_BITS-1:0] pix_t;
    typedef pix_t win_t [WIN_SIZE];

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        pix_t                value;
        logic                is_min;
        logic                last;
        logic                done;
    } res_t;

    typedef struct packed {
        logic                 valid;
        logic [DEC_COUNT-1:0] want;
        logic                 r_ge1;
        logic                 r_ge2;
        logic                 c_ge1;
        logic                 c_ge2;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        pix_t                 pixel;
    } stage_t;

    function automatic logic is_local_min(win_t w, int wr, int wc, logic up, logic down,
                                          logic left, logic right);
        int                      xr;
        int                      xc;
        logic                    ok;
        logic                    m;
        pix_t                    centre;
        logic [WIN_IDX_BITS-1:0] idx;
        m      = 1'b1;
        idx    = WIN_IDX_BITS'(wr * WIN_DIM + wc);
        centre = w[idx];
        for (int n = 0; n < NEIGHBOURS; n++)
        begin
            xr = wr + OFF_ROW[n];
            xc = wc + OFF_COL[n];
            ok = (xr >= 0) && (xr < WIN_DIM) && (xc >= 0) && (xc < WIN_DIM);
            if (OFF_ROW[n] < 0)
                ok = ok && up;
            if (OFF_ROW[n] > 0)
                ok = ok && down;
            if (OFF_COL[n] < 0)
                ok = ok && left;
            if (OFF_COL[n] > 0)
                ok = ok && right;
            if (ok)
            begin
                idx = WIN_IDX_BITS'(xr * WIN_DIM + xc);
                if (centre >= w[idx])
                    m = 1'b0;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: sv/gslm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module gslm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/gslm_window.sv
// The 3x3 window and the four parallel minimum decisions made on each shift.
`default_nettype none

module gslm_window
    import gslm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire stage_t                  stage,
    input  wire pix_t                    older_data,
    input  wire pix_t                    prev_data,
    output res_t [DEC_COUNT-1:0]         res,
    output logic [DEC_COUNT-1:0]         res_valid
);

    win_t                 window_reg;
    win_t                 window_next;
    logic [DEC_COUNT-1:0] last;

    always_comb
    begin
        for (int i = 0; i < WIN_DIM; i++)
        begin
            window_next[i * WIN_DIM + 0] = window_reg[i * WIN_DIM + 1];
            window_next[i * WIN_DIM + 1] = window_reg[i * WIN_DIM + 2];
        end
        window_next[2] = older_data;
        window_next[5] = prev_data;
        window_next[8] = stage.pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_SIZE; i++)
                window_reg[i] <= '0;
        end
        else if (stage.valid)
        begin
            window_reg <= window_next;
        end
    end

    always_comb
    begin
        last[DEC_HERE]       = stage.want[DEC_HERE];
        last[DEC_LEFT]       = stage.want[DEC_LEFT] && !stage.want[DEC_HERE];
        last[DEC_ABOVE]      = stage.want[DEC_ABOVE] && !stage.want[DEC_LEFT]
                               && !stage.want[DEC_HERE];
        last[DEC_ABOVE_LEFT] = stage.want[DEC_ABOVE_LEFT] && !stage.want[DEC_ABOVE]
                               && !stage.want[DEC_LEFT] && !stage.want[DEC_HERE];

        res[DEC_ABOVE_LEFT].row    = stage.row - ROW_BITS'(1);
        res[DEC_ABOVE_LEFT].col    = stage.col - COL_BITS'(1);
        res[DEC_ABOVE_LEFT].value  = window_next[4];
        res[DEC_ABOVE_LEFT].is_min = is_local_min(window_next, 1, 1, stage.r_ge2, 1'b1,
                                                  stage.c_ge2, 1'b1);
        res[DEC_ABOVE_LEFT].last   = last[DEC_ABOVE_LEFT];
        res[DEC_ABOVE_LEFT].done   = 1'b0;

        res[DEC_ABOVE].row    = stage.row - ROW_BITS'(1);
        res[DEC_ABOVE].col    = stage.col;
        res[DEC_ABOVE].value  = window_next[5];
        res[DEC_ABOVE].is_min = is_local_min(window_next, 1, 2, stage.r_ge2, 1'b1,
                                             stage.c_ge1, 1'b0);
        res[DEC_ABOVE].last   = last[DEC_ABOVE];
        res[DEC_ABOVE].done   = 1'b0;

        res[DEC_LEFT].row    = stage.row;
        res[DEC_LEFT].col    = stage.col - COL_BITS'(1);
        res[DEC_LEFT].value  = window_next[7];
        res[DEC_LEFT].is_min = is_local_min(window_next, 2, 1, stage.r_ge1, 1'b0,
                                            stage.c_ge2, 1'b1);
        res[DEC_LEFT].last   = last[DEC_LEFT];
        res[DEC_LEFT].done   = 1'b0;

        res[DEC_HERE].row    = stage.row;
        res[DEC_HERE].col    = stage.col;
        res[DEC_HERE].value  = window_next[8];
        res[DEC_HERE].is_min = is_local_min(window_next, 2, 2, stage.r_ge1, 1'b0,
                                            stage.c_ge1, 1'b0);
        res[DEC_HERE].last   = last[DEC_HERE];
        res[DEC_HERE].done   = 1'b1;

        res_valid = stage.want & {DEC_COUNT{stage.valid}};
    end

endmodule

`default_nettype wire

FILE: sv/gslm_res_fifo.sv
// Result queue that packs up to four decisions per cycle and drains one per transfer.
`default_nettype none

module gslm_res_fifo
    import gslm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [DEC_COUNT-1:0]     push_valid,
    input  wire res_t [DEC_COUNT-1:0]     push_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output res_t                          out_data,
    output logic [FIFO_CNT_BITS-1:0]      count
);

    res_t                     slots_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic [FIFO_CNT_BITS-1:0] count_next;
    logic [FIFO_CNT_BITS-1:0] push_num;
    logic [FIFO_PTR_BITS-1:0] slot [DEC_COUNT];
    logic                     pop;

    always_comb
    begin
        for (int k = 0; k < DEC_COUNT; k++)
        begin
            slot[k] = wr_ptr_reg;
            for (int j = 0; j < k; j++)
                slot[k] = slot[k] + FIFO_PTR_BITS'(push_valid[j]);
        end
        push_num    = FIFO_CNT_BITS'($countones(push_valid));
        pop         = (count_reg != '0) && out_ready;
        count_next  = count_reg + push_num - FIFO_CNT_BITS'(pop);
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push_num);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEC_COUNT; k++)
        begin
            if (push_valid[k])
                slots_reg[slot[k]] <= push_data[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = slots_reg[rd_ptr_reg];
    assign count     = count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue holds more entries than its depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + {1'b0, push_num}) <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH))
        else $error("result queue written beyond its free space");
`endif

endmodule

`default_nettype wire

FILE: sv/grid_strict_local_minimum.sv
// Strict 3x3 local-minimum detector over a raster-ordered grid, top level.
// A result passes the window stage register and the result queue before it is presented;
// further results of the same input follow one per cycle while out_ready is high.
// Throughput: one input per cycle while the result queue has room (in_ready); results leave
// one per cycle from an eight-entry queue while out_ready is high, which paces the last row.
// Reset clears the counters, window, queue and registers (both counts to one); the line
// stores are not cleared and need no clearing pass.
`default_nettype none

module grid_strict_local_minimum
    import gslm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CNT_BITS-1:0]     cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [PIXEL_BITS-1:0]   pixel_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [ROW_BITS-1:0]          out_row,
    output logic [COL_BITS-1:0]          out_col,
    output logic [PIXEL_BITS-1:0]        out_value,
    output logic                         is_minimum,
    output logic                         last_of_item,
    output logic                         frame_done
);

    logic [CNT_BITS-1:0]      row_count_reg;
    logic [CNT_BITS-1:0]      col_count_reg;
    logic [ROW_BITS-1:0]      row_counter_reg;
    logic [ROW_BITS-1:0]      row_counter_next;
    logic [COL_BITS-1:0]      col_counter_reg;
    logic [COL_BITS-1:0]      col_counter_next;
    logic [CNT_BITS-1:0]      nrows;
    logic [CNT_BITS-1:0]      ncols;
    logic [ROW_BITS-1:0]      cur_row;
    logic [COL_BITS-1:0]      cur_col;
    logic [CNT_BITS-1:0]      r_inc;
    logic [CNT_BITS-1:0]      c_inc;
    logic                     r_last;
    logic                     c_last;
    logic                     in_accept;

    stage_t                   stage_reg;
    stage_t                   stage_next;
    logic                     hit_reg;
    logic                     hit_next;
    pix_t                     fwd_prev_reg;
    pix_t                     fwd_older_reg;
    logic [PIXEL_BITS-1:0]    prev_rdata;
    logic [PIXEL_BITS-1:0]    older_rdata;
    pix_t                     prev_eff;
    pix_t                     older_eff;

    res_t [DEC_COUNT-1:0]     dec_res;
    logic [DEC_COUNT-1:0]     dec_valid;
    res_t                     fifo_out;
    logic [FIFO_CNT_BITS-1:0] fifo_count;
    logic [FIFO_CNT_BITS:0]   pending;

    always_comb
    begin
        if (row_count_reg == '0)
            nrows = CNT_BITS'(1);
        else if (row_count_reg > MAX_ROWS_CNT)
            nrows = MAX_ROWS_CNT;
        else
            nrows = row_count_reg;

        if (col_count_reg == '0)
            ncols = CNT_BITS'(1);
        else if (col_count_reg > MAX_COLS_CNT)
            ncols = MAX_COLS_CNT;
        else
            ncols = col_count_reg;

        if (({1'b0, row_counter_reg} >= nrows) || ({1'b0, col_counter_reg} >= ncols))
        begin
            cur_row = '0;
            cur_col = '0;
        end
        else
        begin
            cur_row = row_counter_reg;
            cur_col = col_counter_reg;
        end

        r_inc  = {1'b0, cur_row} + CNT_BITS'(1);
        c_inc  = {1'b0, cur_col} + CNT_BITS'(1);
        r_last = (r_inc == nrows);
        c_last = (c_inc == ncols);

        if (c_inc >= ncols)
        begin
            col_counter_next = '0;
            row_counter_next = (r_inc >= nrows) ? '0 : r_inc[ROW_BITS-1:0];
        end
        else
        begin
            col_counter_next = c_inc[COL_BITS-1:0];
            row_counter_next = cur_row;
        end
    end

    always_comb
    begin
        stage_next.valid                = in_accept;
        stage_next.r_ge1                = (cur_row != '0);
        stage_next.r_ge2                = (cur_row >= ROW_BITS'(2));
        stage_next.c_ge1                = (cur_col != '0);
        stage_next.c_ge2                = (cur_col >= COL_BITS'(2));
        stage_next.want[DEC_ABOVE_LEFT] = stage_next.r_ge1 && stage_next.c_ge1;
        stage_next.want[DEC_ABOVE]      = stage_next.r_ge1 && c_last;
        stage_next.want[DEC_LEFT]       = r_last && stage_next.c_ge1;
        stage_next.want[DEC_HERE]       = r_last && c_last;
        stage_next.row                  = cur_row;
        stage_next.col                  = cur_col;
        stage_next.pixel                = pix_t'(pixel_value);
        hit_next                        = in_accept && stage_reg.valid
                                          && (stage_reg.col == cur_col);
    end

    assign pending   = {1'b0, fifo_count}
                     + (FIFO_CNT_BITS + 1)'($countones(stage_reg.want
                                                       & {DEC_COUNT{stage_reg.valid}}));
    assign in_ready  = (pending <= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH - DEC_COUNT));
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= CNT_BITS'(1);
            col_count_reg   <= CNT_BITS'(1);
            row_counter_reg <= '0;
            col_counter_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:
                begin
                    row_count_reg   <= cfg_data;
                    row_counter_reg <= '0;
                    col_counter_reg <= '0;
                end
                CFG_COL_COUNT:
                begin
                    col_count_reg   <= cfg_data;
                    row_counter_reg <= '0;
                    col_counter_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_accept)
        begin
            row_counter_reg <= row_counter_next;
            col_counter_reg <= col_counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fwd_prev_reg  <= stage_reg.pixel;
            fwd_older_reg <= prev_eff;
        end
    end

    // The entry written by the item ahead is read in the same cycle when both share a column.
    assign prev_eff  = hit_reg ? fwd_prev_reg  : pix_t'(prev_rdata);
    assign older_eff = hit_reg ? fwd_older_reg : pix_t'(older_rdata);

    gslm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_prev_row_store (
        .clk   (clk),
        .we    (stage_reg.valid),
        .waddr (stage_reg.col),
        .wdata (stage_reg.pixel),
        .re    (in_accept),
        .raddr (cur_col),
        .rdata (prev_rdata)
    );

    gslm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_older_row_store (
        .clk   (clk),
        .we    (stage_reg.valid),
        .waddr (stage_reg.col),
        .wdata (prev_eff),
        .re    (in_accept),
        .raddr (cur_col),
        .rdata (older_rdata)
    );

    gslm_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage_reg),
        .older_data (older_eff),
        .prev_data  (prev_eff),
        .res        (dec_res),
        .res_valid  (dec_valid)
    );

    gslm_res_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (dec_valid),
        .push_data  (dec_res),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (fifo_out),
        .count      (fifo_count)
    );

    assign out_row      = fifo_out.row;
    assign out_col      = fifo_out.col;
    assign out_value    = fifo_out.value;
    assign is_minimum   = fifo_out.is_min;
    assign last_of_item = fifo_out.last;
    assign frame_done   = fifo_out.done;

`ifndef ASSERT_OFF
    a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> stage_reg.valid)
        else $error("accepted transfer did not reach the window stage");

    a_fwd_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> stage_reg.valid)
        else $error("forwarded line-store data without an item in the window stage");
`endif

endmodule

`default_nettype wire
